// ----- src/rgb_led_strip_serializer_core_macros.svh -----
// Assertion macros shared by the serializer checker
`ifndef RGB_LED_STRIP_SERIALIZER_CORE_MACROS_SVH
`define RGB_LED_STRIP_SERIALIZER_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define RLSS_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check a consequence in the cycle after its cause
`define RLSS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- src/rlss_pkg.sv -----
// Shared types, codes and helpers of the LED strip serializer
`default_nettype none

package rlss_pkg;

   localparam int MAX_LEDS        = 256;
   localparam int PIXEL_IDX_WIDTH = 8;
   localparam int PIXEL_BITS      = 24;
   localparam int LED_COUNT_WIDTH = 9;
   localparam int BIT_PTR_WIDTH   = 5;
   localparam int TICK_WIDTH      = 16;
   localparam int CSR_IDX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Command codes
   localparam logic [2:0] MODE_TICK       = 3'd0;
   localparam logic [2:0] MODE_SET        = 3'd1;
   localparam logic [2:0] MODE_SET_SHOW   = 3'd2;
   localparam logic [2:0] MODE_SHOW       = 3'd3;
   localparam logic [2:0] MODE_CLEAR_SHOW = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_BUSY  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LED_COUNT  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ONE_HIGH   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ZERO_HIGH  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BIT_PERIOD = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LATCH_LOW  = 3'd4;

   typedef struct packed {
      logic [LED_COUNT_WIDTH-1:0] led_count;
      logic [7:0]                 one_high_ticks;
      logic [7:0]                 zero_high_ticks;
      logic [7:0]                 bit_period_ticks;
      logic [TICK_WIDTH-1:0]      latch_low_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic                  step;
      logic                  load;
      logic [PIXEL_BITS-1:0] load_pixel;
   } seq_ctrl_type;

   typedef struct packed {
      logic                       sending;
      logic                       line;
      logic                       load_next;
      logic [PIXEL_IDX_WIDTH-1:0] pixel_pointer;
   } seq_status_type;

   // Clamp the programmed LED count to the store depth
   function automatic logic [LED_COUNT_WIDTH-1:0] eff_count(
      input logic [LED_COUNT_WIDTH-1:0] led_count
   );
      logic [LED_COUNT_WIDTH-1:0] max_count;
      max_count = LED_COUNT_WIDTH'(MAX_LEDS);
      return (led_count > max_count) ? max_count : led_count;
   endfunction

endpackage

`default_nettype wire

// ----- src/rlss_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module rlss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/rlss_frame_seq.sv -----
// Frame sequencer: latch timing, bit timing and the pixel shift register
`default_nettype none

module rlss_frame_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rlss_pkg::cfg_type       cfg,
   input  wire rlss_pkg::seq_ctrl_type  ctrl,
   output rlss_pkg::seq_status_type     status
);

   logic                                     sending_ff, sending_in;
   logic                                     latch_ff, latch_in;
   logic [rlss_pkg::PIXEL_IDX_WIDTH-1:0]     pixel_ptr_ff, pixel_ptr_in;
   logic [rlss_pkg::BIT_PTR_WIDTH-1:0]       bit_ptr_ff, bit_ptr_in;
   logic [rlss_pkg::TICK_WIDTH-1:0]          tick_ff, tick_in;
   logic [rlss_pkg::PIXEL_BITS-1:0]          shift_ff, shift_in;

   logic [rlss_pkg::LED_COUNT_WIDTH-1:0]     eff;
   logic [rlss_pkg::TICK_WIDTH:0]            tick_inc;
   logic                                     latch_end;
   logic                                     period_end;
   logic [7:0]                               high_ticks;
   logic                                     last_bit;
   logic                                     last_pixel;

   // Decode where the waveform stands this tick
   always_comb begin
      eff        = rlss_pkg::eff_count(cfg.led_count);
      tick_inc   = {1'b0, tick_ff} + (rlss_pkg::TICK_WIDTH + 1)'(1);
      latch_end  = tick_inc >= {1'b0, cfg.latch_low_ticks};
      period_end = tick_inc >= (rlss_pkg::TICK_WIDTH + 1)'(cfg.bit_period_ticks);
      high_ticks = shift_ff[rlss_pkg::PIXEL_BITS-1] ? cfg.one_high_ticks
                                                     : cfg.zero_high_ticks;
      last_bit   = bit_ptr_ff >= rlss_pkg::BIT_PTR_WIDTH'(rlss_pkg::PIXEL_BITS - 1);
      last_pixel = ({1'b0, pixel_ptr_ff} + rlss_pkg::LED_COUNT_WIDTH'(1)) >= eff;
   end

   // Report line level and whether the step opens a new pixel
   always_comb begin
      status.sending       = sending_ff;
      status.line          = sending_ff && !latch_ff &&
                             (tick_ff < rlss_pkg::TICK_WIDTH'(high_ticks));
      status.pixel_pointer = pixel_ptr_ff;
      if (!sending_ff) begin
         status.load_next = 1'b0;
      end else if (latch_ff) begin
         status.load_next = latch_end && (eff != '0);
      end else begin
         status.load_next = period_end && last_bit && !last_pixel;
      end
   end

   // Advance the frame by one tick, start a frame, or load a pixel
   always_comb begin
      sending_in   = sending_ff;
      latch_in     = latch_ff;
      pixel_ptr_in = pixel_ptr_ff;
      bit_ptr_in   = bit_ptr_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      if (ctrl.start) begin
         sending_in   = 1'b1;
         latch_in     = 1'b1;
         pixel_ptr_in = '0;
         bit_ptr_in   = '0;
         tick_in      = '0;
      end else if (ctrl.load) begin
         shift_in = ctrl.load_pixel;
      end else if (ctrl.step && sending_ff) begin
         if (latch_ff) begin
            if (latch_end) begin
               tick_in      = '0;
               latch_in     = 1'b0;
               pixel_ptr_in = '0;
               bit_ptr_in   = '0;
               if (eff == '0) begin
                  sending_in = 1'b0;
               end
            end else begin
               tick_in = tick_inc[rlss_pkg::TICK_WIDTH-1:0];
            end
         end else if (period_end) begin
            tick_in = '0;
            if (last_bit) begin
               bit_ptr_in = '0;
               if (last_pixel) begin
                  sending_in = 1'b0;
               end else begin
                  pixel_ptr_in = pixel_ptr_ff + rlss_pkg::PIXEL_IDX_WIDTH'(1);
               end
            end else begin
               bit_ptr_in = bit_ptr_ff + rlss_pkg::BIT_PTR_WIDTH'(1);
               shift_in   = {shift_ff[rlss_pkg::PIXEL_BITS-2:0], 1'b0};
            end
         end else begin
            tick_in = tick_inc[rlss_pkg::TICK_WIDTH-1:0];
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff   <= 1'b0;
         latch_ff     <= 1'b0;
         pixel_ptr_ff <= '0;
         bit_ptr_ff   <= '0;
         tick_ff      <= '0;
      end else begin
         sending_ff   <= sending_in;
         latch_ff     <= latch_in;
         pixel_ptr_ff <= pixel_ptr_in;
         bit_ptr_ff   <= bit_ptr_in;
         tick_ff      <= tick_in;
      end
   end

   // Hold the bits of the pixel on the line
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

// ----- src/rgb_led_strip_serializer_core.sv -----
// Top level of the RGB LED strip serializer: command handling and pixel store
//
// Drives a single-wire, pulse-width coded LED strip from a 256-entry store of
// 24-bit colors. Every request is one waveform tick and returns one response
// carrying the status, the line level of that tick and the frame-busy flag.
// A request is decoded, then advances the waveform once the response slot
// is free; a tick that moves the frame to a new pixel then holds off the
// next request for the registered read of the pixel store into the 24-bit
// shift register that feeds the line one bit per bit period.
// The store reads as zero right after reset through per-entry valid bits, so
// no clearing pass is needed; clear-and-show drops the shown entries at once.
// Register writes are always ready and must be made while no request is open.
`default_nettype none

module rgb_led_strip_serializer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_mode,
   input  wire logic [7:0]                          req_pixel_index,
   input  wire logic [7:0]                          req_red,
   input  wire logic [7:0]                          req_green,
   input  wire logic [7:0]                          req_blue,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic                                     rsp_line_level,
   output logic                                     rsp_busy_res,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rlss_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [rlss_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMD   = 3'd1;
   localparam logic [2:0] ST_TICK  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;

   logic [2:0]                           state_ff, state_in;
   rlss_pkg::cfg_type                    cfg_ff, cfg_in;
   logic [2:0]                           mode_ff;
   logic [rlss_pkg::PIXEL_IDX_WIDTH-1:0] index_ff;
   logic [7:0]                           red_ff, green_ff, blue_ff;
   logic [1:0]                           cmd_status_ff, cmd_status_in;
   logic                                 cmd_busy_ff, cmd_busy_in;
   logic [rlss_pkg::MAX_LEDS-1:0]        valid_ff, valid_in;
   logic                                 rd_valid_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]                           rsp_status_ff;
   logic                                 rsp_line_ff;
   logic                                 rsp_busy_ff;

   logic                                 accept;
   logic                                 out_free;
   logic                                 do_write;
   logic                                 do_clear;
   logic                                 do_start;
   logic                                 do_tick;
   logic [rlss_pkg::LED_COUNT_WIDTH-1:0] eff;
   logic [rlss_pkg::PIXEL_BITS-1:0]      rd_data;
   rlss_pkg::seq_ctrl_type               seq_ctrl;
   rlss_pkg::seq_status_type             seq_status;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eff       = rlss_pkg::eff_count(cfg_ff.led_count);
   assign csr_ready = 1'b1;

   // Take register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rlss_pkg::REG_LED_COUNT:
               cfg_in.led_count = csr_data[rlss_pkg::LED_COUNT_WIDTH-1:0];
            rlss_pkg::REG_ONE_HIGH:   cfg_in.one_high_ticks   = csr_data[7:0];
            rlss_pkg::REG_ZERO_HIGH:  cfg_in.zero_high_ticks  = csr_data[7:0];
            rlss_pkg::REG_BIT_PERIOD: cfg_in.bit_period_ticks = csr_data[7:0];
            rlss_pkg::REG_LATCH_LOW:  cfg_in.latch_low_ticks  = csr_data;
            default: ;
         endcase
      end
   end

   // Decode the command against the frame state
   always_comb begin
      cmd_status_in = cmd_status_ff;
      cmd_busy_in   = cmd_busy_ff;
      do_write      = 1'b0;
      do_clear      = 1'b0;
      do_start      = 1'b0;
      if (state_ff == ST_CMD) begin
         cmd_status_in = rlss_pkg::STATUS_OK;
         unique case (mode_ff) inside
            rlss_pkg::MODE_SET, rlss_pkg::MODE_SET_SHOW: begin
               if (seq_status.sending) begin
                  cmd_status_in = rlss_pkg::STATUS_BUSY;
               end else if ({1'b0, index_ff} < eff) begin
                  do_write = 1'b1;
                  do_start = (mode_ff == rlss_pkg::MODE_SET_SHOW);
               end else begin
                  cmd_status_in = rlss_pkg::STATUS_RANGE;
               end
            end
            rlss_pkg::MODE_SHOW: begin
               if (seq_status.sending) begin
                  cmd_status_in = rlss_pkg::STATUS_BUSY;
               end else begin
                  do_start = 1'b1;
               end
            end
            rlss_pkg::MODE_CLEAR_SHOW: begin
               if (seq_status.sending) begin
                  cmd_status_in = rlss_pkg::STATUS_BUSY;
               end else begin
                  do_clear = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: ;
         endcase
         cmd_busy_in = seq_status.sending || do_start;
      end
   end

   // Mark written entries valid, drop the cleared ones
   always_comb begin
      valid_in = valid_ff;
      if (do_clear) begin
         for (int i = 0; i < rlss_pkg::MAX_LEDS; i++) begin
            if (rlss_pkg::LED_COUNT_WIDTH'(i) < eff) begin
               valid_in[i] = 1'b0;
            end
         end
      end
      if (do_write) begin
         valid_in[index_ff] = 1'b1;
      end
   end

   // Step the frame when the response slot is free
   assign do_tick = (state_ff == ST_TICK) && out_free;

   always_comb begin
      seq_ctrl.start      = do_start;
      seq_ctrl.step       = do_tick;
      seq_ctrl.load       = (state_ff == ST_LOAD);
      seq_ctrl.load_pixel = rd_valid_ff ? rd_data : '0;
   end

   // Sequence one request
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_CMD;
         ST_CMD:   state_in = ST_TICK;
         ST_TICK: begin
            if (do_tick) begin
               state_in = seq_status.load_next ? ST_FETCH : ST_IDLE;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Fill and drain the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_IDLE;
         cfg_ff.led_count        <= rlss_pkg::LED_COUNT_WIDTH'(8);
         cfg_ff.one_high_ticks   <= 8'd16;
         cfg_ff.zero_high_ticks  <= 8'd8;
         cfg_ff.bit_period_ticks <= 8'd25;
         cfg_ff.latch_low_ticks  <= rlss_pkg::TICK_WIDTH'(1000);
         valid_ff                <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture request payload and per-request results
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         index_ff <= req_pixel_index;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
      cmd_status_ff <= cmd_status_in;
      cmd_busy_ff   <= cmd_busy_in;
      if (state_ff == ST_FETCH) begin
         rd_valid_ff <= valid_ff[seq_status.pixel_pointer];
      end
      if (do_tick) begin
         rsp_status_ff <= cmd_status_ff;
         rsp_line_ff   <= seq_status.line;
         rsp_busy_ff   <= cmd_busy_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_line_level = rsp_line_ff;
   assign rsp_busy_res   = rsp_busy_ff;

   // Pixel store, green in the top byte
   rlss_ram #(
      .WIDTH (rlss_pkg::PIXEL_BITS),
      .DEPTH (rlss_pkg::MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (index_ff),
      .wr_data ({green_ff, red_ff, blue_ff}),
      .rd_en   (state_ff == ST_FETCH),
      .rd_addr (seq_status.pixel_pointer),
      .rd_data (rd_data)
   );

   rlss_frame_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .ctrl   (seq_ctrl),
      .status (seq_status)
   );

endmodule

`default_nettype wire

// ----- src/rlss_checker.sv -----
// Port-level checks of the serializer, bound to the top level
`default_nettype none

`include "rgb_led_strip_serializer_core_macros.svh"

module rlss_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_line_level,
   input wire logic       rsp_busy_res
);

   // A stalled response keeps its contents
   `RLSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      $stable({rsp_valid, rsp_status, rsp_line_level, rsp_busy_res}),
      "stalled response changed")

   // The line only goes high inside a frame
   `RLSS_ASSERT_SAME(a_line_in_frame, clock, reset, rsp_valid && rsp_line_level,
      rsp_busy_res, "line high outside a frame")

   // A busy refusal only happens while a frame runs
   `RLSS_ASSERT_SAME(a_busy_refusal, clock, reset,
      rsp_valid && (rsp_status == rlss_pkg::STATUS_BUSY), rsp_busy_res,
      "busy refusal while idle")

   // A rejected index starts no frame
   `RLSS_ASSERT_SAME(a_range_idle, clock, reset,
      rsp_valid && (rsp_status == rlss_pkg::STATUS_RANGE),
      !rsp_busy_res && !rsp_line_level, "rejected index started a frame")

endmodule

bind rgb_led_strip_serializer_core rlss_checker u_checker (.*);

`default_nettype wire
